FILE: hw/rtl/pah_pkg.sv
package pah_pkg;

    localparam int MAX_PUMPS = 8;
    localparam int LEAD_W    = 3;
    localparam int CNT_W     = 4;
    localparam int MASK_W    = 8;
    localparam int LVL_W     = 8;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_EVENT = 2'd1,
        REQ_ON    = 2'd2,
        REQ_OFF   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        REG_PUMP_COUNT = 2'd0,
        REG_LOW_THRESH = 2'd1,
        REG_HIGH_THRESH = 2'd2,
        REG_AUTO_MODE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] pump_count;
        logic [LVL_W-1:0] thresh_lo;
        logic [LVL_W-1:0] thresh_hi;
        logic             auto_mode;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [LEAD_W-1:0] lead;
        logic [CNT_W-1:0]  installed;
        logic [MASK_W-1:0] broken_mask;
    } t_rot_req;

    typedef struct packed {
        logic              done;
        logic              none_found;
        logic [LEAD_W-1:0] lead;
    } t_rot_rsp;

endpackage

FILE: hw/rtl/pah_if.sv
interface pah_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       comparator_high;
    logic [7:0] broken_mask;

    modport source (output valid, req_type, comparator_high, broken_mask, input ready);
    modport sink   (input valid, req_type, comparator_high, broken_mask, output ready);
endinterface

interface pah_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pump_on_mask;
    logic [7:0] ref_level;
    logic       edge_falling;
    logic       phase_falling;
    logic [2:0] lead_pump;
    logic       no_healthy_pump;

    modport source (output valid, pump_on_mask, ref_level, edge_falling, phase_falling,
                    lead_pump, no_healthy_pump, input ready);
    modport sink   (input valid, pump_on_mask, ref_level, edge_falling, phase_falling,
                    lead_pump, no_healthy_pump, output ready);
endinterface

FILE: hw/rtl/pump_alternator_hysteresis_top.sv
// Pump alternator with pressure hysteresis.
// Input channel i_item carries one request per item: start, comparator event,
// manual on or manual off, plus the sampled comparator level and the broken mask.
// Output channel o_result returns exactly one item per request, holding the
// pump drive mask, comparator reference, armed edge, phase, lead pump and the
// no-healthy-pump flag as they stand after the request.
// Config sits on an APB-style port (pump count, low/high threshold, auto mode);
// write it only while the block is idle. pready is tied high.
// The result is registered and valid once the state reaches S_OUT. A
// comparator event that ends the rising phase (auto mode, two or more pumps
// installed) first rotates the lead pump through a search unit that tests one
// candidate pump per cycle. One item at a time: i_item.ready is high only in
// idle, so a new item is taken only after the last result has been accepted.
// When the receiver stalls the result holds steady and no new item is taken.
// Reset (synchronous, active low) clears phase, lead, pump drive and reference
// to zero and restores register defaults (high threshold 255).
module pump_alternator_hysteresis_top
    import pah_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    pah_in_if.sink            i_item,
    pah_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_OUT    = 3'b100
    } t_state;

    t_cfg     w_cfg;
    t_rot_req w_rot_req;
    t_rot_rsp w_rot_rsp;

    t_state            r_state, n_state;
    logic              r_phase, n_phase;
    logic [LEAD_W-1:0] r_lead, n_lead;
    logic              r_running, n_running;
    logic [LVL_W-1:0]  r_ref, n_ref;
    logic              r_flag, n_flag;

    logic [CNT_W-1:0]  w_installed;
    logic              w_accept;
    logic              w_rotate;
    t_req              w_req;

    pah_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pah_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rot_req),
        .o_rsp   (w_rot_rsp)
    );

    // saturate the pump count at the supported maximum
    assign w_installed = (w_cfg.pump_count > CNT_W'(MAX_PUMPS)) ? CNT_W'(MAX_PUMPS)
                                                                 : w_cfg.pump_count;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_req        = t_req'(i_item.req_type);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_lead    = r_lead;
        n_running = r_running;
        n_ref     = r_ref;
        n_flag    = r_flag;
        w_rotate  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_flag  = 1'b0;
                    n_state = S_OUT;
                    case (w_req)
                        REQ_START: begin
                            n_running = 1'b0;
                            if (w_cfg.auto_mode) begin
                                if (i_item.comparator_high) begin
                                    n_phase = 1'b1;
                                    n_ref   = w_cfg.thresh_lo;
                                end else begin
                                    n_phase   = 1'b0;
                                    n_ref     = w_cfg.thresh_hi;
                                    n_running = 1'b1;
                                end
                            end
                        end
                        REQ_EVENT: begin
                            if (w_cfg.auto_mode) begin
                                if (!r_phase) begin
                                    // rising -> falling: stop and, with two or more pumps, hand over the lead
                                    n_phase   = 1'b1;
                                    n_ref     = w_cfg.thresh_lo;
                                    n_running = 1'b0;
                                    if (w_installed >= CNT_W'(2)) begin
                                        w_rotate = 1'b1;
                                        n_state  = S_SEARCH;
                                    end
                                end else begin
                                    n_phase   = 1'b0;
                                    n_ref     = w_cfg.thresh_hi;
                                    n_running = 1'b1;
                                end
                            end
                        end
                        REQ_ON: begin
                            if (!w_cfg.auto_mode) begin
                                n_running = 1'b1;
                            end
                        end
                        REQ_OFF: begin
                            if (!w_cfg.auto_mode) begin
                                n_running = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_rot_rsp.done) begin
                    n_state = S_OUT;
                    if (w_rot_rsp.none_found) begin
                        n_flag = 1'b1;  // every pump broken: keep the lead
                    end else begin
                        n_lead = w_rot_rsp.lead;
                    end
                end
            end
            S_OUT: begin
                if (o_result.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_rot_req.start       = w_rotate;
    assign w_rot_req.lead        = r_lead;
    assign w_rot_req.installed   = w_installed;
    assign w_rot_req.broken_mask = i_item.broken_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= 1'b0;
            r_lead    <= '0;
            r_running <= 1'b0;
            r_ref     <= '0;
            r_flag    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_lead    <= n_lead;
            r_running <= n_running;
            r_ref     <= n_ref;
            r_flag    <= n_flag;
        end
    end

    // the user must keep config stable while busy (unchecked here); the drive mask is formed from live state
    assign o_result.valid           = (r_state == S_OUT);
    assign o_result.pump_on_mask    = (r_running && ({1'b0, r_lead} < w_installed))
                                      ? (MASK_W'(1) << r_lead) : '0;
    assign o_result.ref_level       = r_ref;
    assign o_result.edge_falling    = r_phase;
    assign o_result.phase_falling   = r_phase;
    assign o_result.lead_pump       = r_lead;
    assign o_result.no_healthy_pump = r_flag;

endmodule

FILE: hw/rtl/pah_apb_regs.sv
module pah_apb_regs
    import pah_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pump_count <= '0;
            r_cfg.thresh_lo  <= '0;
            r_cfg.thresh_hi  <= '1;
            r_cfg.auto_mode  <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PUMP_COUNT:  r_cfg.pump_count <= pwdata[CNT_W-1:0];
                REG_LOW_THRESH:  r_cfg.thresh_lo  <= pwdata[LVL_W-1:0];
                REG_HIGH_THRESH: r_cfg.thresh_hi  <= pwdata[LVL_W-1:0];
                REG_AUTO_MODE:   r_cfg.auto_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_PUMP_COUNT:  prdata[CNT_W-1:0] = r_cfg.pump_count;
            REG_LOW_THRESH:  prdata[LVL_W-1:0] = r_cfg.thresh_lo;
            REG_HIGH_THRESH: prdata[LVL_W-1:0] = r_cfg.thresh_hi;
            REG_AUTO_MODE:   prdata[0]         = r_cfg.auto_mode;
            default:         prdata            = '0;
        endcase
    end

endmodule

FILE: hw/rtl/pah_rotate.sv
module pah_rotate
    import pah_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rot_req i_req,
    output t_rot_rsp o_rsp
);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cand;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_n;
    logic [MASK_W-1:0] r_mask;
    logic [CNT_W-1:0]  w_next;
    logic              w_healthy;
    logic              w_last;

    // one candidate per cycle, wrapping at the installed count
    always_comb begin
        w_next = r_cand + CNT_W'(1);
        if (w_next >= r_n) begin
            w_next = '0;
        end
    end

    assign w_healthy = !r_mask[w_next[LEAD_W-1:0]];
    assign w_last    = (r_k + CNT_W'(1)) == r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (w_healthy || w_last)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cand <= {1'b0, i_req.lead};
            r_k    <= '0;
            r_n    <= i_req.installed;
            r_mask <= i_req.broken_mask;
        end else if (r_busy) begin
            r_cand <= w_next;
            r_k    <= r_k + CNT_W'(1);
        end
    end

    assign o_rsp.done       = r_busy && (w_healthy || w_last);
    assign o_rsp.none_found = !w_healthy;
    assign o_rsp.lead       = w_next[LEAD_W-1:0];

endmodule
